### hw/rtl/tssd_pkg.sv
// Shared types and constants for the two-stage switch debouncer.
`default_nettype none

package tssd_pkg;

    localparam int FIELD_W    = 24;  // width of every level mask
    localparam int TIME_W     = 32;  // millisecond timestamp
    localparam int THR_W      = 16;  // threshold registers
    localparam int CFG_IDX_W  = 8;   // config register index
    localparam int IN_DATA_W  = 56;  // raw_sample + time_now
    localparam int OUT_DATA_W = 80;  // three masks + flag, padded to bytes

    localparam logic [THR_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [THR_W-1:0] STABLE_RESET   = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TIME = 8'd0,
        REG_STABLE_TIME   = 8'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [THR_W-1:0] debounce_time;
        logic [THR_W-1:0] stable_time;
    } t_thresh;

    typedef struct packed {
        logic              en;   // item moves to the result register this cycle
        logic [TIME_W-1:0] now;
    } t_step;

endpackage

`default_nettype wire

### hw/rtl/two_stage_switch_debouncer.sv
// Top level of the two-stage multichannel switch debouncer.
//
//  Channel   Dir  Handshake                     Content
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[23:0] raw_sample, [55:24] time_now
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[23:0] debounced_mask,
//                                               [47:24] stable_mask, [71:48] unstable_mask,
//                                               [72] new_unstable, [79:73] zero
//  cfg       in   i_cfg_valid/o_cfg_ready       index 0 debounce_time, 1 stable_time
//
// One item per cycle sustained while the output is not held; an accepted item passes the
// input register, then per-channel subtract-compare lanes into the result register.
// Reset is synchronous, active low, and clears all levels, stamps and handshake state;
// thresholds return to 50 ms and 1000 ms. The config port is always ready.
// A stalled output holds its result; the input register still takes one more item,
// and s_axis_tready drops only when both registers are full.
`default_nettype none

module two_stage_switch_debouncer #(
    parameter int CHANNELS = 24   // channels kept, 1..32; masks are cut to 24 bits
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // sample stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [23:0] raw_sample, [55:24] time_now
    input  wire logic [tssd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [23:0] debounced_mask, [47:24] stable_mask, [71:48] unstable_mask,
    // [72] new_unstable, [79:73] zero
    output logic [tssd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tssd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tssd_pkg::THR_W-1:0]      i_cfg_data
);
    import tssd_pkg::*;

    // input register
    logic               r_in_valid;
    logic [FIELD_W-1:0] r_raw;
    logic [TIME_W-1:0]  r_now;

    // result register
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_deb_mask;
    logic [FIELD_W-1:0] r_stab_mask;
    logic [FIELD_W-1:0] r_unst_mask;
    logic               r_new_unst;

    logic    w_move;
    logic    w_accept;
    t_step   w_step;
    t_thresh w_thresh;

    logic [CHANNELS-1:0] w_deb_cur, w_stab_cur, w_deb_nxt, w_stab_nxt;
    logic [FIELD_W-1:0]  w_deb_f, w_stab_f, w_prev_unst, w_unst_f;

    // item leaves the input register whenever the result register is free or drains
    assign w_move        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_move;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_step.en  = w_move;
    assign w_step.now = r_now;

    tssd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_thresh    (w_thresh)
    );

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++) begin : g_lane
            logic w_raw_bit;
            // channels past the field width never see a raw high level
            if (gi < FIELD_W) begin : g_raw
                assign w_raw_bit = r_raw[gi];
            end else begin : g_noraw
                assign w_raw_bit = 1'b0;
            end
            tssd_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_step      (w_step),
                .i_thresh    (w_thresh),
                .i_raw       (w_raw_bit),
                .o_deb       (w_deb_cur[gi]),
                .o_stab      (w_stab_cur[gi]),
                .o_deb_next  (w_deb_nxt[gi]),
                .o_stab_next (w_stab_nxt[gi])
            );
        end

        // map kept channels onto the 24-bit masks
        for (gi = 0; gi < FIELD_W; gi++) begin : g_field
            if (gi < CHANNELS) begin : g_used
                assign w_deb_f[gi]     = w_deb_nxt[gi];
                assign w_stab_f[gi]    = w_stab_nxt[gi];
                assign w_prev_unst[gi] = w_deb_cur[gi] ^ w_stab_cur[gi];
            end else begin : g_unused
                assign w_deb_f[gi]     = 1'b0;
                assign w_stab_f[gi]    = 1'b0;
                assign w_prev_unst[gi] = 1'b0;
            end
        end
    endgenerate

    assign w_unst_f = w_deb_f ^ w_stab_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_move);
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw <= s_axis_tdata[FIELD_W-1:0];
            r_now <= s_axis_tdata[FIELD_W +: TIME_W];
        end
        if (w_move) begin
            r_deb_mask  <= w_deb_f;
            r_stab_mask <= w_stab_f;
            r_unst_mask <= w_unst_f;
            r_new_unst  <= |(w_unst_f & ~w_prev_unst);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - 3*FIELD_W - 1){1'b0}},
                            r_new_unst, r_unst_mask, r_stab_mask, r_deb_mask};

`ifndef SYNTH
    // unstable mask in a shown result is always debounced XOR stable
    a_unst_xor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_unst_mask == (r_deb_mask ^ r_stab_mask)))
        else $error("unstable mask mismatch");

    // a rising-unstable flag needs at least one unstable channel
    a_new_unst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_new_unst) |-> (r_unst_mask != '0))
        else $error("new_unstable without unstable channel");

    // input side stalls only when both registers are full and the output is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled without full pipeline");

    // a held result does not change under backpressure
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_deb_mask)))
        else $error("held result changed");
`endif

endmodule

`default_nettype wire

### hw/rtl/tssd_cfg.sv
// Threshold register file for the debouncer.
`default_nettype none

module tssd_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tssd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tssd_pkg::THR_W-1:0]     i_cfg_data,
    output tssd_pkg::t_thresh                   o_thresh
);
    import tssd_pkg::*;

    t_thresh r_thresh;
    t_thresh n_thresh;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_thresh = r_thresh;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEBOUNCE_TIME: n_thresh.debounce_time = i_cfg_data;
                REG_STABLE_TIME:   n_thresh.stable_time   = i_cfg_data;
                default:           n_thresh = r_thresh;  // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.debounce_time <= DEBOUNCE_RESET;
            r_thresh.stable_time   <= STABLE_RESET;
        end else begin
            r_thresh <= n_thresh;
        end
    end

    assign o_thresh = r_thresh;

endmodule

`default_nettype wire

### hw/rtl/tssd_lane.sv
// One debouncer channel: candidate, debounced and stable levels with their stamps.
`default_nettype none

module tssd_lane (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tssd_pkg::t_step   i_step,
    input  wire tssd_pkg::t_thresh i_thresh,
    input  wire logic              i_raw,
    output logic                   o_deb,
    output logic                   o_stab,
    output logic                   o_deb_next,
    output logic                   o_stab_next
);
    import tssd_pkg::*;

    logic              r_cand, n_cand;
    logic [TIME_W-1:0] r_cand_stamp, n_cand_stamp;
    logic              r_deb, n_deb;
    logic [TIME_W-1:0] r_deb_stamp, n_deb_stamp;
    logic              r_stab, n_stab;
    logic [TIME_W-1:0] w_cand_age;
    logic [TIME_W-1:0] w_deb_age;

    always_comb begin
        n_cand       = r_cand;
        n_cand_stamp = r_cand_stamp;
        n_deb        = r_deb;
        n_deb_stamp  = r_deb_stamp;
        n_stab       = r_stab;

        // candidate follows raw, restamped on every change
        if (i_raw != r_cand) begin
            n_cand       = i_raw;
            n_cand_stamp = i_step.now;
        end

        // wrapping age against the candidate stamp
        w_cand_age = i_step.now - n_cand_stamp;
        if ((n_cand != r_deb) &&
            (w_cand_age >= {{(TIME_W-THR_W){1'b0}}, i_thresh.debounce_time})) begin
            n_deb       = n_cand;
            n_deb_stamp = i_step.now;
        end

        w_deb_age = i_step.now - n_deb_stamp;
        if ((n_deb != r_stab) &&
            (w_deb_age >= {{(TIME_W-THR_W){1'b0}}, i_thresh.stable_time})) begin
            n_stab = n_deb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand       <= 1'b0;
            r_cand_stamp <= '0;
            r_deb        <= 1'b0;
            r_deb_stamp  <= '0;
            r_stab       <= 1'b0;
        end else if (i_step.en) begin
            r_cand       <= n_cand;
            r_cand_stamp <= n_cand_stamp;
            r_deb        <= n_deb;
            r_deb_stamp  <= n_deb_stamp;
            r_stab       <= n_stab;
        end
    end

    assign o_deb       = r_deb;
    assign o_stab      = r_stab;
    assign o_deb_next  = n_deb;
    assign o_stab_next = n_stab;

endmodule

`default_nettype wire

### tb/two_stage_switch_debouncer_tb.sv
// Self-checking testbench for the two-stage switch debouncer: sample stream in, level masks out.
`timescale 1ns / 1ps

module two_stage_switch_debouncer_tb;
    import tssd_pkg::*;

    localparam int NCH = FIELD_W;  // channels kept by the default build

    typedef struct {
        bit [FIELD_W-1:0] debounced;
        bit [FIELD_W-1:0] stable_lv;
        bit [FIELD_W-1:0] unstable;
        bit               rose;
    } t_levels;

    // Tracks the per-channel debounce state and holds the level masks still owed.
    class debounce_scoreboard;
        bit [THR_W-1:0]   debounce_thr;
        bit [THR_W-1:0]   stable_thr;
        bit [FIELD_W-1:0] cand_lv;
        bit [FIELD_W-1:0] deb_lv;
        bit [FIELD_W-1:0] stab_lv;
        bit [FIELD_W-1:0] unstab_lv;
        bit [TIME_W-1:0]  cand_stamp [NCH];
        bit [TIME_W-1:0]  deb_stamp [NCH];
        t_levels          owed_levels [$];
        int               samples;
        int               results;
        int               errors;
        int               deb_flips;
        int               stab_flips;
        int               rises;

        function new();
            debounce_thr = DEBOUNCE_RESET;
            stable_thr   = STABLE_RESET;
            cand_lv      = '0;
            deb_lv       = '0;
            stab_lv      = '0;
            unstab_lv    = '0;
            foreach (cand_stamp[ch]) begin
                cand_stamp[ch] = '0;
                deb_stamp[ch]  = '0;
            end
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [THR_W-1:0] val);
            case (idx)
                REG_DEBOUNCE_TIME: debounce_thr = val;
                REG_STABLE_TIME:   stable_thr   = val;
                default: ;  // unknown index: dropped
            endcase
        endfunction

        function void note_sample(bit [FIELD_W-1:0] raw, bit [TIME_W-1:0] now);
            t_levels          lv;
            bit [FIELD_W-1:0] prev_unstab;
            bit [TIME_W-1:0]  elapsed;
            prev_unstab = unstab_lv;
            for (int ch = 0; ch < NCH; ch++) begin
                if (raw[ch] != cand_lv[ch]) begin
                    cand_lv[ch]    = raw[ch];
                    cand_stamp[ch] = now;
                end
                elapsed = now - cand_stamp[ch];
                if (cand_lv[ch] != deb_lv[ch] && elapsed >= {16'd0, debounce_thr}) begin
                    deb_lv[ch]    = cand_lv[ch];
                    deb_stamp[ch] = now;
                    deb_flips++;
                end
                elapsed = now - deb_stamp[ch];
                if (deb_lv[ch] != stab_lv[ch] && elapsed >= {16'd0, stable_thr}) begin
                    stab_lv[ch] = deb_lv[ch];
                    stab_flips++;
                end
            end
            unstab_lv    = deb_lv ^ stab_lv;
            lv.debounced = deb_lv;
            lv.stable_lv = stab_lv;
            lv.unstable  = unstab_lv;
            lv.rose      = |(unstab_lv & ~prev_unstab);
            if (lv.rose) rises++;
            owed_levels.push_back(lv);
            samples++;
        endfunction

        function void compare_field(string name, bit [FIELD_W-1:0] want, bit [FIELD_W-1:0] got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %h got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(bit [OUT_DATA_W-1:0] data);
            t_levels lv;
            results++;
            if (owed_levels.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with nothing expected", $time, data);
                return;
            end
            lv = owed_levels.pop_front();
            compare_field("debounced_mask", lv.debounced, data[FIELD_W-1:0]);
            compare_field("stable_mask", lv.stable_lv, data[2*FIELD_W-1:FIELD_W]);
            compare_field("unstable_mask", lv.unstable, data[3*FIELD_W-1:2*FIELD_W]);
            compare_field("new_unstable", FIELD_W'(lv.rose), FIELD_W'(data[3*FIELD_W]));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [THR_W-1:0]      i_cfg_data;

    debounce_scoreboard sb;
    bit                 quiet = 1'b0;   // no idling on either side while set
    bit [TIME_W-1:0]    cur_time;
    bit [FIELD_W-1:0]   cur_raw;
    int                 settings;

    two_stage_switch_debouncer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one sample and returns at the edge that takes it.
    task automatic send_sample(bit [FIELD_W-1:0] raw, bit [TIME_W-1:0] now);
        if (!quiet && $urandom_range(0, 99) < 17) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, raw};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(raw, now);
    endtask

    // Leaves i_cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [THR_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // Thresholds change only with the pipe empty; two stray indices go along to prove they are ignored.
    task automatic set_thresholds(bit [THR_W-1:0] deb, bit [THR_W-1:0] stab);
        s_axis_tvalid <= 1'b0;
        while (sb.owed_levels.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(REG_DEBOUNCE_TIME, deb);
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_STABLE_TIME) + 1, (1 << CFG_IDX_W) - 1)),
                  THR_W'($urandom));
        write_reg(REG_STABLE_TIME, stab);
        write_reg({CFG_IDX_W{1'b1}}, {THR_W{1'b1}});
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // Mostly forward time in steps sized to the thresholds, with bounce, jumps,
    // backward time and full-range noise mixed in.
    task automatic run_random(int count);
        int unsigned fine_span;
        int unsigned coarse_span;
        int unsigned pick;
        fine_span   = sb.debounce_thr / 4 + 3;
        coarse_span = sb.stable_thr + sb.stable_thr / 4 + 3;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      cur_time += $urandom_range(0, fine_span);
            else if (pick < 82) cur_time += $urandom_range(0, coarse_span);
            else if (pick < 88) cur_time -= $urandom_range(1, 1000);
            else if (pick < 93) cur_time = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 15)      cur_raw ^= FIELD_W'($urandom & $urandom & $urandom);
            else if (pick < 27) cur_raw ^= FIELD_W'(1) << $urandom_range(0, NCH - 1);
            else if (pick < 30) cur_raw = FIELD_W'($urandom);
            send_sample(cur_raw, cur_time);
        end
    endtask

    // Result side: random stalls plus two long hold-offs that back the pipe up.
    initial begin
        int hold_left;
        int hold_mark;
        hold_left     = 0;
        hold_mark     = 300;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (hold_left == 0 && sb.results == hold_mark) begin
                hold_left = 150;
                hold_mark = (hold_mark == 300) ? 1700 : -1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 17) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int waited;
        sb            = new();
        settings      = 1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_DEBOUNCE_TIME;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset thresholds: walk one edge through both stages, then wrap and backward time.
        send_sample(24'h000000, 32'd0);
        send_sample(24'hFFFFFF, 32'd100);
        send_sample(24'hFFFFFF, 32'd149);       // one short of debounce
        send_sample(24'hFFFFFF, 32'd150);       // debounced, all unstable
        send_sample(24'hFFFFFF, 32'd1149);
        send_sample(24'hFFFFFF, 32'd1150);      // stable
        send_sample(24'h000001, 32'd1160);
        send_sample(24'hA5A5A5, 32'd1200);
        send_sample(24'h5A5A5A, 32'd1220);      // bounce
        send_sample(24'h5A5A5A, 32'd1300);
        send_sample(24'h5A5A5A, 32'd1000);      // time backwards passes the stable stage
        send_sample(24'h000000, 32'hFFFF_FFF0);
        send_sample(24'h000000, 32'hFFFF_FFFF);
        send_sample(24'h000000, 32'h0000_0021); // 49 across the wrap
        send_sample(24'h000000, 32'h0000_0022); // 50 across the wrap
        send_sample(24'hFFFFFF, 32'h7FFF_FFFF);
        send_sample(24'hFFFFFF, 32'h8000_0000);
        send_sample(24'h800000, 32'hFFFF_FFFF);
        cur_time = 32'h0001_0000;
        cur_raw  = 24'h800000;
        run_random(450);

        // Zero thresholds: a level passes both stages on the sample that brings it.
        set_thresholds('0, '0);
        send_sample(24'h123456, cur_time);
        send_sample(24'hEDCBA9, cur_time);
        send_sample(24'h000000, cur_time + 1);
        cur_raw = '0;
        run_random(350);

        // Largest thresholds, starting just short of the time wrap.
        set_thresholds({THR_W{1'b1}}, {THR_W{1'b1}});
        send_sample(24'hFFFFFF, 32'hFFFF_0000);
        send_sample(24'hFFFFFF, 32'hFFFF_FFFE);  // 65534
        send_sample(24'hFFFFFF, 32'hFFFF_FFFF);  // 65535
        cur_time = 32'hFFFF_0000 + $urandom_range(0, 65535);
        cur_raw  = 24'hFFFFFF;
        run_random(350);

        // Short thresholds; the first part runs back to back on both sides.
        set_thresholds(16'd5, 16'd20);
        quiet <= 1'b1;
        run_random(300);
        quiet <= 1'b0;
        run_random(100);

        set_thresholds(THR_W'($urandom_range(0, 300)), THR_W'($urandom_range(0, 3000)));
        run_random(400);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.owed_levels.size() > 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (5) @(posedge i_clk);
        if (sb.owed_levels.size() > 0) begin
            sb.errors += sb.owed_levels.size();
            $display("%0t: %0d expected results never arrived", $time, sb.owed_levels.size());
        end
        $display("Ran %0d samples over %0d threshold settings, %0d results checked.",
                 sb.samples, settings, sb.results);
        $display("Saw %0d debounce and %0d stable transitions, %0d unstable rises.",
                 sb.deb_flips, sb.stab_flips, sb.rises);
        if (sb.errors == 0) begin
            $display("two_stage_switch_debouncer: match");
        end else begin
            $display("two_stage_switch_debouncer: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("two_stage_switch_debouncer: mismatch");
        $finish;
    end

endmodule
